// ===== design/hashed_block_cache_directory_assert.svh =====
// Assertion macros for the hashed block cache directory.
`ifndef HASHED_BLOCK_CACHE_DIRECTORY_ASSERT_SVH
`define HASHED_BLOCK_CACHE_DIRECTORY_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define HBCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define HBCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/hbcd_pkg.sv =====
// Shared types, constants and sequencer states of the cache directory.
`timescale 1ns / 1ps

package hbcd_pkg;

	localparam int ENTRIES_DEF  = 1024;
	localparam int TAG_BITS_DEF = 64;

	localparam int WIN_W    = 11;
	localparam int TIME_W   = 48;
	localparam int KEY_W    = 64;
	localparam int ROFF_W   = 10;
	localparam int SLOT_W   = 10;
	localparam int RATE_W   = 7;
	localparam int CNT_W    = 32;
	localparam int SUM_W64  = 64;

	// shared divider: dividend and divisor widths, step counter
	localparam int DVD_W  = 66;
	localparam int DVS_W  = 34;
	localparam int STEP_W = 7;

	localparam logic [WIN_W-1:0] WIN_RESET = 11'd4;
	localparam int ALPHA_K = 10;
	localparam int PCT     = 100;

	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_INSERT = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [KEY_W-1:0]  key_hash;
		logic [ROFF_W-1:0] random_offset;
		logic [TIME_W-1:0] now_us;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [RATE_W-1:0] hit_rate_percent;
		logic [TIME_W-1:0] mean_lifespan_us;
	} rsp_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HOME_GO,
		ST_HOME_WAIT,
		ST_DISPATCH,
		ST_LOOKUP,
		ST_INS_GO,
		ST_INS_WAIT,
		ST_SUM_GO,
		ST_SUM_WAIT,
		ST_INS_RD,
		ST_INS_WR,
		ST_LS_GO,
		ST_LS_WAIT,
		ST_HR_GO,
		ST_HR_WAIT,
		ST_DONE
	} state_t;

endpackage

// ===== design/hbcd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module hbcd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hbcd_pkg::div_req_t             ctl,
	input  logic [hbcd_pkg::DVD_W-1:0]     dividend,
	input  logic [hbcd_pkg::DVS_W-1:0]     divisor,
	output hbcd_pkg::div_sts_t             sts,
	output logic [hbcd_pkg::DVD_W-1:0]     quotient,
	output logic [hbcd_pkg::DVS_W-1:0]     remainder
);

	localparam int DVD_W  = hbcd_pkg::DVD_W;
	localparam int DVS_W  = hbcd_pkg::DVS_W;
	localparam int STEP_W = hbcd_pkg::STEP_W;

	logic              busy_q, done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q, quo_q;
	logic [DVS_W-1:0]  dvs_q, rem_q;
	logic [DVS_W:0]    trial, diff;
	logic              ge;

	// dividend arrives left-aligned; its top bit feeds the partial remainder
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== design/hashed_block_cache_directory.sv =====
// Top level of the hashed block cache tag directory.
//
//  channel | dir | handshake              | beat
//  --------+-----+------------------------+------------------------------
//  req     | in  | req_valid / req_ready  | func, key_hash, offset, now
//  rsp     | out | rsp_valid / rsp_ready  | hit, slot, hit rate, lifespan
//  cfg     | in  | cfg_we                 | probe window, 11 bits
//
// One request at a time; req_ready is high only while the sequencer idles.
// Lookup: probes a window of W slots from the home slot (one tag read a cycle,
// compare in the cycle after the read), ending early on a hit. Insert: a
// remainder in the shared divider, then a read and a write. Tick: up to two
// divisions in the shared divider. A table size that is not a power of two
// adds a division for the home slot and another for the insert wrap.
// After reset the tag store is swept clear entry by entry; req_ready
// stays low meanwhile. A finished result sits in the rsp register, so the
// next request is taken while rsp waits on rsp_ready.
`timescale 1ns / 1ps
`include "hashed_block_cache_directory_assert.svh"

module hashed_block_cache_directory #(
	parameter int ENTRIES  = hbcd_pkg::ENTRIES_DEF,
	parameter int TAG_BITS = hbcd_pkg::TAG_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  hbcd_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output hbcd_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [hbcd_pkg::WIN_W-1:0]  cfg_wdata
);

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam bit IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;
	localparam int SUM_W   = IDX_W + 12;
	localparam int TIME_W  = hbcd_pkg::TIME_W;
	localparam int MW      = 1 + TIME_W + TAG_BITS;
	localparam int WIN_W   = hbcd_pkg::WIN_W;
	localparam int CNT_W   = hbcd_pkg::CNT_W;
	localparam int DVD_W   = hbcd_pkg::DVD_W;
	localparam int DVS_W   = hbcd_pkg::DVS_W;
	localparam int STEP_W  = hbcd_pkg::STEP_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
	localparam logic [TIME_W-1:0] MAX48 = '1;

	hbcd_pkg::state_t state_q, state_d;

	// tag store: {valid, created time, tag}
	logic [MW-1:0]    mem_q [ENTRIES];
	logic [MW-1:0]    rd_q;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [MW-1:0]    wr_data;
	logic             mem_we;

	logic [IDX_W-1:0] clr_addr_q;
	logic [WIN_W-1:0] win_q, weff;
	hbcd_pkg::req_t   req_q;
	logic [IDX_W-1:0] home_q, slot_q, addr_q, cmp_addr_q;
	logic [SUM_W-1:0] sum_q;
	logic             hit_q;
	logic [WIN_W-1:0] iss_left_q, cmp_left_q;
	logic             cmp_vld_q, issue, match;

	logic [CNT_W-1:0]  hit_cnt_q, miss_cnt_q, ls_cnt_q;
	logic [63:0]       ls_sum_q;
	logic [TIME_W-1:0] sm_ls_q;
	logic [hbcd_pkg::RATE_W-1:0] sm_hr_q;

	logic              out_valid_q;
	hbcd_pkg::rsp_t    rsp_q;

	hbcd_pkg::div_req_t div_ctl;
	hbcd_pkg::div_sts_t div_sts;
	logic [DVD_W-1:0]   div_dvd, div_quo;
	logic [DVS_W-1:0]   div_dvs, div_rem;

	// tick arithmetic
	logic [3:0]        k_ls, k_hr;
	logic [51:0]       ls_prod;
	logic [10:0]       hr_prod;
	logic [CNT_W:0]    hr_n;
	logic [38:0]       hr_x;
	logic [TIME_W-1:0] age;
	logic [63:0]       age64;
	logic [WIN_W-1:0]  roff_mod;
	logic [16:0]       slot_ext;

	assign weff     = (win_q == '0) ? WIN_W'(1) : win_q;
	assign match    = rd_q[MW-1] && (rd_q[TAG_BITS-1:0] == req_q.key_hash[TAG_BITS-1:0]);
	assign k_ls     = 4'(hbcd_pkg::ALPHA_K) - ls_cnt_q[3:0];
	assign ls_prod  = 52'(sm_ls_q) * 52'(k_ls);
	assign hr_n     = {1'b0, hit_cnt_q} + {1'b0, miss_cnt_q};
	assign k_hr     = 4'(hbcd_pkg::ALPHA_K) - hr_n[3:0];
	assign hr_prod  = 11'(sm_hr_q) * 11'(k_hr);
	assign hr_x     = 39'(hit_cnt_q) * 39'(hbcd_pkg::PCT);
	assign age      = req_q.now_us - rd_q[MW-2:TAG_BITS];
	assign age64    = 64'(age);
	assign roff_mod = div_rem[WIN_W-1:0];
	assign slot_ext = 17'(slot_q);

	hbcd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.sts       (div_sts),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hbcd_pkg::ST_CLEAR: begin
				if (clr_addr_q == LAST) state_d = hbcd_pkg::ST_IDLE;
			end
			hbcd_pkg::ST_IDLE: begin
				if (req_valid) begin
					priority if (req.func == hbcd_pkg::FUNC_TICK) begin
						state_d = hbcd_pkg::ST_LS_GO;
					end else if (req.func == hbcd_pkg::FUNC_LOOKUP ||
						req.func == hbcd_pkg::FUNC_INSERT) begin
						state_d = IS_POW2 ? hbcd_pkg::ST_DISPATCH : hbcd_pkg::ST_HOME_GO;
					end else begin
						state_d = hbcd_pkg::ST_DONE;
					end
				end
			end
			hbcd_pkg::ST_HOME_GO:   state_d = hbcd_pkg::ST_HOME_WAIT;
			hbcd_pkg::ST_HOME_WAIT: begin
				if (div_sts.done) state_d = hbcd_pkg::ST_DISPATCH;
			end
			hbcd_pkg::ST_DISPATCH: begin
				state_d = (req_q.func == hbcd_pkg::FUNC_LOOKUP) ?
					hbcd_pkg::ST_LOOKUP : hbcd_pkg::ST_INS_GO;
			end
			hbcd_pkg::ST_LOOKUP: begin
				if (cmp_vld_q && (match || cmp_left_q == WIN_W'(1)))
					state_d = hbcd_pkg::ST_DONE;
			end
			hbcd_pkg::ST_INS_GO:   state_d = hbcd_pkg::ST_INS_WAIT;
			hbcd_pkg::ST_INS_WAIT: begin
				if (div_sts.done)
					state_d = IS_POW2 ? hbcd_pkg::ST_INS_RD : hbcd_pkg::ST_SUM_GO;
			end
			hbcd_pkg::ST_SUM_GO:   state_d = hbcd_pkg::ST_SUM_WAIT;
			hbcd_pkg::ST_SUM_WAIT: begin
				if (div_sts.done) state_d = hbcd_pkg::ST_INS_RD;
			end
			hbcd_pkg::ST_INS_RD: state_d = hbcd_pkg::ST_INS_WR;
			hbcd_pkg::ST_INS_WR: state_d = hbcd_pkg::ST_DONE;
			hbcd_pkg::ST_LS_GO: begin
				state_d = (ls_cnt_q == '0) ? hbcd_pkg::ST_HR_GO : hbcd_pkg::ST_LS_WAIT;
			end
			hbcd_pkg::ST_LS_WAIT: begin
				if (div_sts.done) state_d = hbcd_pkg::ST_HR_GO;
			end
			hbcd_pkg::ST_HR_GO: begin
				state_d = (hr_n == '0) ? hbcd_pkg::ST_DONE : hbcd_pkg::ST_HR_WAIT;
			end
			hbcd_pkg::ST_HR_WAIT: begin
				if (div_sts.done) state_d = hbcd_pkg::ST_DONE;
			end
			hbcd_pkg::ST_DONE: begin
				if (!out_valid_q || rsp_ready) state_d = hbcd_pkg::ST_IDLE;
			end
			default: state_d = hbcd_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: memory port and divider operands
	always_comb begin
		req_ready     = 1'b0;
		issue         = 1'b0;
		rd_addr       = slot_q;
		wr_addr       = slot_q;
		wr_data       = {1'b1, req_q.now_us, req_q.key_hash[TAG_BITS-1:0]};
		mem_we        = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.steps = STEP_W'(DVD_W);
		div_dvd       = '0;
		div_dvs       = DVS_W'(1);
		unique case (state_q)
			hbcd_pkg::ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
			end
			hbcd_pkg::ST_IDLE: req_ready = 1'b1;
			hbcd_pkg::ST_HOME_GO: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = STEP_W'(hbcd_pkg::KEY_W);
				div_dvd       = {req_q.key_hash, {(DVD_W - hbcd_pkg::KEY_W){1'b0}}};
				div_dvs       = DVS_W'(ENTRIES);
			end
			hbcd_pkg::ST_LOOKUP: begin
				issue   = iss_left_q != '0;
				rd_addr = addr_q;
			end
			hbcd_pkg::ST_INS_GO: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = STEP_W'(hbcd_pkg::ROFF_W);
				div_dvd       = {req_q.random_offset, {(DVD_W - hbcd_pkg::ROFF_W){1'b0}}};
				div_dvs       = DVS_W'(weff);
			end
			hbcd_pkg::ST_SUM_GO: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = STEP_W'(SUM_W);
				div_dvd       = {sum_q, {(DVD_W - SUM_W){1'b0}}};
				div_dvs       = DVS_W'(ENTRIES);
			end
			hbcd_pkg::ST_INS_WR: mem_we = 1'b1;
			hbcd_pkg::ST_LS_GO: begin
				div_ctl.start = ls_cnt_q != '0;
				if (ls_cnt_q > CNT_W'(hbcd_pkg::ALPHA_K)) begin
					div_dvd = DVD_W'(ls_sum_q);
					div_dvs = DVS_W'(ls_cnt_q);
				end else begin
					div_dvd = DVD_W'(ls_sum_q) + DVD_W'(ls_prod);
					div_dvs = DVS_W'(hbcd_pkg::ALPHA_K);
				end
			end
			hbcd_pkg::ST_HR_GO: begin
				div_ctl.start = hr_n != '0;
				if (hr_n > (CNT_W + 1)'(hbcd_pkg::ALPHA_K)) begin
					div_dvd = DVD_W'(hr_x);
					div_dvs = DVS_W'(hr_n);
				end else begin
					div_dvd = DVD_W'(hr_x) + DVD_W'(hr_prod);
					div_dvs = DVS_W'(hbcd_pkg::ALPHA_K);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[wr_addr] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hbcd_pkg::ST_CLEAR;
			clr_addr_q  <= '0;
			win_q       <= hbcd_pkg::WIN_RESET;
			cmp_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			ls_cnt_q    <= '0;
			ls_sum_q    <= '0;
			sm_ls_q     <= '0;
			sm_hr_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) win_q <= cfg_wdata;
			if (state_q == hbcd_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;

			cmp_vld_q <= issue;

			if (state_q == hbcd_pkg::ST_LOOKUP && cmp_vld_q) begin
				if (match) begin
					if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
				end else if (cmp_left_q == WIN_W'(1)) begin
					if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end

			// an evicted entry adds its age to the lifespan totals
			if (state_q == hbcd_pkg::ST_INS_WR && rd_q[MW-1]) begin
				ls_sum_q <= (ls_sum_q > ~age64) ? '1 : ls_sum_q + age64;
				if (ls_cnt_q != '1) ls_cnt_q <= ls_cnt_q + 1'b1;
			end

			if (state_q == hbcd_pkg::ST_LS_WAIT && div_sts.done)
				sm_ls_q <= (div_quo > DVD_W'(MAX48)) ? MAX48 : div_quo[TIME_W-1:0];
			if (state_q == hbcd_pkg::ST_HR_WAIT && div_sts.done)
				sm_hr_q <= (div_quo > DVD_W'(hbcd_pkg::PCT)) ?
					hbcd_pkg::RATE_W'(hbcd_pkg::PCT) : div_quo[hbcd_pkg::RATE_W-1:0];

			if (state_q == hbcd_pkg::ST_DONE && (!out_valid_q || rsp_ready))
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	// request payload and probe bookkeeping
	always_ff @(posedge clk) begin
		if (state_q == hbcd_pkg::ST_IDLE && req_valid) begin
			req_q  <= req;
			hit_q  <= 1'b0;
			slot_q <= '0;
			home_q <= req.key_hash[IDX_W-1:0];
		end
		if (state_q == hbcd_pkg::ST_HOME_WAIT && div_sts.done)
			home_q <= div_rem[IDX_W-1:0];
		if (state_q == hbcd_pkg::ST_DISPATCH) begin
			addr_q     <= home_q;
			iss_left_q <= weff;
			cmp_left_q <= weff;
		end
		if (issue) begin
			addr_q     <= (addr_q == LAST) ? '0 : addr_q + 1'b1;
			iss_left_q <= iss_left_q - 1'b1;
			cmp_addr_q <= addr_q;
		end
		if (state_q == hbcd_pkg::ST_LOOKUP && cmp_vld_q) begin
			cmp_left_q <= cmp_left_q - 1'b1;
			if (match) begin
				hit_q  <= 1'b1;
				slot_q <= cmp_addr_q;
			end
		end
		if (state_q == hbcd_pkg::ST_INS_WAIT && div_sts.done) begin
			sum_q  <= SUM_W'(home_q) + SUM_W'(roff_mod);
			slot_q <= IDX_W'(SUM_W'(home_q) + SUM_W'(roff_mod));
		end
		if (state_q == hbcd_pkg::ST_SUM_WAIT && div_sts.done)
			slot_q <= div_rem[IDX_W-1:0];
		if (state_q == hbcd_pkg::ST_DONE && (!out_valid_q || rsp_ready)) begin
			rsp_q.hit              <= hit_q;
			rsp_q.slot             <= slot_ext[hbcd_pkg::SLOT_W-1:0];
			rsp_q.hit_rate_percent <= sm_hr_q;
			rsp_q.mean_lifespan_us <= sm_ls_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	`HBCD_ASSERT_IMP(a_mem_we_state, clk, arst_n, mem_we, state_q == hbcd_pkg::ST_CLEAR || state_q == hbcd_pkg::ST_INS_WR, "tag store written outside clear or insert")
	`HBCD_ASSERT_IMP(a_div_idle, clk, arst_n, div_ctl.start, !div_sts.busy, "divider started while busy")
	`HBCD_ASSERT_IMP(a_probe_left, clk, arst_n, state_q == hbcd_pkg::ST_LOOKUP, cmp_left_q != '0, "lookup with no probes left")
	`HBCD_ASSERT_NXT(a_done_loads, clk, arst_n, state_q == hbcd_pkg::ST_DONE && (!out_valid_q || rsp_ready), rsp_valid && state_q == hbcd_pkg::ST_IDLE, "result not presented")
	`HBCD_ASSERT_IMP(a_rate_cap, clk, arst_n, 1'b1, sm_hr_q <= hbcd_pkg::RATE_W'(hbcd_pkg::PCT), "hit rate above 100")

endmodule
